// ----- design/assert_macros.svh -----
// Assertion macros shared by the icon contrast backfill RTL.
// Depends on nothing; each user supplies signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ICB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ICB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/icb_pkg.sv -----
// Shared types, codes and arithmetic helpers for the icon contrast backfill block.
// Used by icb_ctrl, icb_datapath and the top level; depends on nothing.
package icb_pkg;

   // Function codes of an input beat.
   localparam logic FUNC_MEASURE = 1'b0;
   localparam logic FUNC_COMPOSE = 1'b1;

   // Kind codes of a result beat.
   localparam logic KIND_DECISION = 1'b0;
   localparam logic KIND_PIXEL    = 1'b1;

   // Decision codes, also the compose mode.
   localparam logic [1:0] DEC_PATH   = 2'd0;
   localparam logic [1:0] DEC_PREMUL = 2'd1;
   localparam logic [1:0] DEC_FILL   = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_THEME  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_PATH_MODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCENT_RED   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCENT_GREEN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCENT_BLUE  = 3'd4;

   // Luma in thousandths; the file order is BGR, so red takes the 299 weight.
   localparam int unsigned LUMA_W = 18;
   localparam logic [LUMA_W-1:0] W_RED   = 18'd299;
   localparam logic [LUMA_W-1:0] W_GREEN = 18'd587;
   localparam logic [LUMA_W-1:0] W_BLUE  = 18'd114;

   // One weighted pixel contributes at most 255000 * 255.
   localparam int unsigned PIX_W = 26;
   localparam longint unsigned PIX_WEIGHT_MAX = 64'd65025000;
   localparam logic [PIX_W-1:0] LUMA_ONE  = 26'd255000;
   localparam logic [PIX_W-1:0] THR_LIGHT = 26'd56100000;   // 220 * 255000
   localparam logic [PIX_W-1:0] THR_DARK  = 26'd7650000;    // 30 * 255000

   typedef struct packed {
      logic load;
      logic calc1;
      logic calc2;
      logic acc;
      logic thr;
      logic decide;
      logic emit;
   } icb_cmd_type;

   typedef struct packed {
      logic func;
      logic last;
   } icb_sts_type;

   // Round-to-nearest of x/255 for x up to 255*255. A tie cannot occur since
   // 255 is odd, so this equals round-half-up.
   function automatic logic [7:0] div255_round(input logic [15:0] x);
      logic [16:0] t;
      logic [16:0] u;
      t = {1'b0, x} + 17'd128;
      u = t + {8'd0, t[16:8]};
      return u[15:8];
   endfunction

endpackage

// ----- design/icb_ctrl.sv -----
// Sequencing state machine of the icon contrast backfill block.
// Depends on icb_pkg and assert_macros.svh; drives icb_datapath by commands.
`include "assert_macros.svh"

module icb_ctrl
   import icb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  icb_sts_type sts,
   output icb_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC1,
      S_CALC2,
      S_ACC,
      S_THR,
      S_DECIDE,
      S_EMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // The output register may be loaded when empty or when its beat leaves now.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == S_IDLE) && req_valid;
      cmd.calc1  = (state_ff == S_CALC1);
      cmd.calc2  = (state_ff == S_CALC2);
      cmd.acc    = (state_ff == S_ACC);
      cmd.thr    = (state_ff == S_THR);
      cmd.decide = (state_ff == S_DECIDE);
      cmd.emit   = (state_ff == S_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_CALC1;
               end
            end
            S_CALC1: begin
               state_ff <= S_CALC2;
            end
            S_CALC2: begin
               if (sts.func == FUNC_COMPOSE) begin
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               if (sts.last) begin
                  state_ff <= S_THR;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_THR: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `ICB_ASSERT(a_emit_into_free_slot, cmd.emit |-> (!rsp_valid_ff || rsp_ready),
      "result loaded over a beat that was not taken")
   `ICB_ASSERT_NEXT(a_thr_then_decide, state_ff == S_THR, state_ff == S_DECIDE,
      "threshold product not followed by the decision step")
   `ICB_ASSERT(a_valid_drops_on_take, $fell(rsp_valid_ff) |-> $past(rsp_ready),
      "result beat withdrawn before it was taken")
   `ICB_ASSERT_NEXT(a_measure_not_last_frees, cmd.acc && !sts.last, req_ready,
      "non-final measure pixel did not release the input side")

endmodule

// ----- design/icb_datapath.sv -----
// Arithmetic, configuration registers and output register of the backfill block.
// Depends on icb_pkg; sequenced by commands from icb_ctrl.
module icb_datapath
   import icb_pkg::*;
#(
   parameter int unsigned MAX_PIXELS = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  icb_cmd_type          cmd,
   output icb_sts_type          sts,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data,
   input  logic                 req_func,
   input  logic [7:0]           req_in_blue,
   input  logic [7:0]           req_in_green,
   input  logic [7:0]           req_in_red,
   input  logic [7:0]           req_in_alpha,
   input  logic                 req_in_last,
   output logic                 rsp_kind,
   output logic [1:0]           rsp_decision,
   output logic [7:0]           rsp_out_blue,
   output logic [7:0]           rsp_out_green,
   output logic [7:0]           rsp_out_red,
   output logic [7:0]           rsp_out_alpha,
   output logic                 rsp_out_last
);

   localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
   localparam longint unsigned SUM_MAX = PIX_WEIGHT_MAX * 64'(MAX_PIXELS);
   localparam int unsigned SUM_W = $clog2(SUM_MAX + 64'd1);
   localparam int unsigned PROD_W = PIX_W + CNT_W;

   // Configuration.
   logic       light_ff, nopath_ff;
   logic [7:0] acc_r_ff, acc_g_ff, acc_b_ff;

   // Captured input beat.
   logic       func_ff, last_ff;
   logic [7:0] b_ff, g_ff, r_ff, a_ff;

   // Intermediate results.
   logic [LUMA_W-1:0] luma_ff;
   logic [PIX_W-1:0]  bgterm_ff, wprod_ff;
   logic [15:0]       mix_b_ff, mix_g_ff, mix_r_ff;
   logic [7:0]        res_b_ff, res_g_ff, res_r_ff, res_a_ff;

   // Accumulation and decision state.
   logic [SUM_W-1:0] sum_ff, thr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [1:0]       mode_ff;

   // Output register.
   logic       kind_ff, out_last_ff;
   logic [1:0] decision_ff;
   logic [7:0] out_b_ff, out_g_ff, out_r_ff, out_a_ff;

   logic [LUMA_W-1:0] luma_in;
   logic [PIX_W-1:0]  wprod_in;
   logic [PROD_W-1:0] thr_full;
   logic [PIX_W-1:0]  thr_const;
   logic              counted;
   logic              contrast_ok;
   logic [7:0]        inv_a;

   assign sts.func = func_ff;
   assign sts.last = last_ff;

   assign inv_a   = ~a_ff;   // 255 - alpha
   assign luma_in = W_RED * {10'd0, r_ff} + W_GREEN * {10'd0, g_ff}
                  + W_BLUE * {10'd0, b_ff};
   assign wprod_in = {8'd0, luma_ff} * {18'd0, a_ff} + bgterm_ff;
   assign counted  = (a_ff != 8'd0) && (count_ff < CNT_W'(MAX_PIXELS));
   assign thr_const = light_ff ? THR_LIGHT : THR_DARK;
   assign thr_full  = PROD_W'(thr_const) * PROD_W'(count_ff);

   always_comb begin
      if (count_ff == '0) begin
         contrast_ok = 1'b0;
      end else if (light_ff) begin
         contrast_ok = (sum_ff <= thr_ff);
      end else begin
         contrast_ok = (sum_ff >= thr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff  <= 1'b0;
         nopath_ff <= 1'b0;
         acc_r_ff  <= 8'd0;
         acc_g_ff  <= 8'd0;
         acc_b_ff  <= 8'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LIGHT_THEME:  light_ff  <= csr_data[0];
            CSR_NO_PATH_MODE: nopath_ff <= csr_data[0];
            CSR_ACCENT_RED:   acc_r_ff  <= csr_data;
            CSR_ACCENT_GREEN: acc_g_ff  <= csr_data;
            CSR_ACCENT_BLUE:  acc_b_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Payload stages; no reset needed.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         b_ff    <= req_in_blue;
         g_ff    <= req_in_green;
         r_ff    <= req_in_red;
         a_ff    <= req_in_alpha;
         last_ff <= req_in_last;
      end
      if (cmd.calc1) begin
         luma_ff   <= luma_in;
         bgterm_ff <= light_ff ? LUMA_ONE * {18'd0, inv_a} : '0;
         if (mode_ff == DEC_FILL) begin
            mix_b_ff <= {8'd0, b_ff} * {8'd0, a_ff} + {8'd0, acc_b_ff} * {8'd0, inv_a};
            mix_g_ff <= {8'd0, g_ff} * {8'd0, a_ff} + {8'd0, acc_g_ff} * {8'd0, inv_a};
            mix_r_ff <= {8'd0, r_ff} * {8'd0, a_ff} + {8'd0, acc_r_ff} * {8'd0, inv_a};
         end else begin
            mix_b_ff <= {8'd0, b_ff} * {8'd0, a_ff};
            mix_g_ff <= {8'd0, g_ff} * {8'd0, a_ff};
            mix_r_ff <= {8'd0, r_ff} * {8'd0, a_ff};
         end
      end
      if (cmd.calc2) begin
         wprod_ff <= wprod_in;
         case (mode_ff)
            DEC_PREMUL: begin
               res_b_ff <= div255_round(mix_b_ff);
               res_g_ff <= div255_round(mix_g_ff);
               res_r_ff <= div255_round(mix_r_ff);
               res_a_ff <= a_ff;
            end
            DEC_FILL: begin
               res_b_ff <= div255_round(mix_b_ff);
               res_g_ff <= div255_round(mix_g_ff);
               res_r_ff <= div255_round(mix_r_ff);
               res_a_ff <= 8'hFF;
            end
            default: begin
               res_b_ff <= b_ff;
               res_g_ff <= g_ff;
               res_r_ff <= r_ff;
               res_a_ff <= a_ff;
            end
         endcase
      end
      if (cmd.thr) begin
         thr_ff <= thr_full[SUM_W-1:0];
      end
      if (cmd.emit) begin
         decision_ff <= mode_ff;
         if (func_ff == FUNC_COMPOSE) begin
            kind_ff     <= KIND_PIXEL;
            out_b_ff    <= res_b_ff;
            out_g_ff    <= res_g_ff;
            out_r_ff    <= res_r_ff;
            out_a_ff    <= res_a_ff;
            out_last_ff <= last_ff;
         end else begin
            kind_ff     <= KIND_DECISION;
            out_b_ff    <= 8'd0;
            out_g_ff    <= 8'd0;
            out_r_ff    <= 8'd0;
            out_a_ff    <= 8'd0;
            out_last_ff <= 1'b1;
         end
      end
   end

   // Running sum, pixel count and the decision that selects the compose mode.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         mode_ff  <= DEC_PATH;
      end else if (cmd.decide) begin
         sum_ff   <= '0;
         count_ff <= '0;
         if (contrast_ok) begin
            mode_ff <= nopath_ff ? DEC_PREMUL : DEC_PATH;
         end else begin
            mode_ff <= DEC_FILL;
         end
      end else if (cmd.acc && counted) begin
         sum_ff   <= sum_ff + SUM_W'(wprod_ff);
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   assign rsp_kind      = kind_ff;
   assign rsp_decision  = decision_ff;
   assign rsp_out_blue  = out_b_ff;
   assign rsp_out_green = out_g_ff;
   assign rsp_out_red   = out_r_ff;
   assign rsp_out_alpha = out_a_ff;
   assign rsp_out_last  = out_last_ff;

endmodule

// ----- design/icon_contrast_backfill.sv -----
// Icon contrast backfill: average-luma measurement and alpha composite of BGRA pixels.
// Depends on icb_pkg, icb_ctrl and icb_datapath.
//
// A measure pixel (func 0) with nonzero alpha adds its alpha-blended luma to an
// exact running sum; the last pixel of the pass yields one decision beat (use
// path, premultiply, or fill) and clears the sum. A compose pixel (func 1) yields
// one pixel beat made according to the latest decision. Items are handled one at
// a time by the sequencer, ready only when idle: a compose pixel passes the load,
// calc1, calc2 and emit steps, an ordinary measure pixel load, calc1, calc2 and
// acc, the last measure pixel these and then thr (threshold multiply), decide
// (compare) and emit; emit waits until a previous result leaves the output register.
// A new pixel may be accepted while the last result still waits there. The
// configuration port is always ready and should be written only while the block is idle.
module icon_contrast_backfill
   import icb_pkg::*;
#(
   parameter int unsigned MAX_PIXELS = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [7:0]           req_in_blue,
   input  logic [7:0]           req_in_green,
   input  logic [7:0]           req_in_red,
   input  logic [7:0]           req_in_alpha,
   input  logic                 req_in_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_kind,
   output logic [1:0]           rsp_decision,
   output logic [7:0]           rsp_out_blue,
   output logic [7:0]           rsp_out_green,
   output logic [7:0]           rsp_out_red,
   output logic [7:0]           rsp_out_alpha,
   output logic                 rsp_out_last
);

   icb_cmd_type cmd;
   icb_sts_type sts;

   assign csr_ready = 1'b1;

   icb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   icb_datapath #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_func      (req_func),
      .req_in_blue   (req_in_blue),
      .req_in_green  (req_in_green),
      .req_in_red    (req_in_red),
      .req_in_alpha  (req_in_alpha),
      .req_in_last   (req_in_last),
      .rsp_kind      (rsp_kind),
      .rsp_decision  (rsp_decision),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_green (rsp_out_green),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_out_last  (rsp_out_last)
   );

endmodule
